### src/tesq_pkg.sv
// Shared types, codes and constants for the trial epoch motor sequencer.
`timescale 1ns / 1ps
`default_nettype none

package tesq_pkg;

   // Width of the trial clock in milliseconds (24 to 32).
   localparam int TimeBits       = 32;
   localparam int ReportInterval = 30;
   localparam int TotalBits      = 25;   // pre + epoch * count + post
   localparam int CmpBits        = 33;   // wide enough for trial time and total
   localparam int FifoDepth      = 4;
   localparam int PtrBits        = $clog2(FifoDepth);
   localparam int CountBits      = $clog2(FifoDepth + 1);
   localparam int CsrDataBits    = 16;
   localparam int CsrIndexBits   = 3;

   // Input actions
   localparam logic [2:0] ACT_TICK    = 3'd0;
   localparam logic [2:0] ACT_START   = 3'd1;
   localparam logic [2:0] ACT_STOP    = 3'd2;
   localparam logic [2:0] ACT_FRAME   = 3'd3;
   localparam logic [2:0] ACT_ENCODER = 3'd4;

   // Event kinds
   localparam logic [2:0] EV_TRIAL_START = 3'd1;
   localparam logic [2:0] EV_EPOCH_START = 3'd2;
   localparam logic [2:0] EV_MOTOR_ON    = 3'd3;
   localparam logic [2:0] EV_MOTOR_OFF   = 3'd4;
   localparam logic [2:0] EV_FRAME       = 3'd5;
   localparam logic [2:0] EV_TRIAL_STOP  = 3'd6;
   localparam logic [2:0] EV_ENCODER     = 3'd7;

   // Register indexes
   localparam logic [CsrIndexBits-1:0] REG_PRE_DURATION   = 3'd0;
   localparam logic [CsrIndexBits-1:0] REG_POST_DURATION  = 3'd1;
   localparam logic [CsrIndexBits-1:0] REG_EPOCH_DURATION = 3'd2;
   localparam logic [CsrIndexBits-1:0] REG_EPOCH_COUNT    = 3'd3;
   localparam logic [CsrIndexBits-1:0] REG_MOTOR_DELAY    = 3'd4;
   localparam logic [CsrIndexBits-1:0] REG_MOTOR_DURATION = 3'd5;
   localparam logic [CsrIndexBits-1:0] REG_MOTOR_ENABLE   = 3'd6;
   localparam logic [CsrIndexBits-1:0] REG_ARMED          = 3'd7;

   // Register reset values
   localparam logic [15:0] PreReset      = 16'd100;
   localparam logic [15:0] PostReset     = 16'd100;
   localparam logic [15:0] EpochDurReset = 16'd500;
   localparam logic [7:0]  EpochCntReset = 8'd3;
   localparam logic [15:0] DelayReset    = 16'd100;
   localparam logic [15:0] MotorDurReset = 16'd300;
   localparam logic [TotalBits-1:0] TotalReset = TotalBits'(100 + 500 * 3 + 100);

   localparam logic [31:0] WheelReset = 32'hFFFF_FC19;   // minus 999

   typedef struct packed {
      logic [2:0]         action;
      logic               from_host;
      logic signed [31:0] encoder_position;
   } req_type;

   typedef struct packed {
      logic [2:0]         event_kind;
      logic [31:0]        event_time;
      logic signed [31:0] event_value;
      logic               trial_running;
      logic               motor_on;
      logic               last;
   } rsp_type;

   // Settings and derived limits handed to the sequencing core
   typedef struct packed {
      logic [15:0]          pre_duration;
      logic [15:0]          epoch_len;     // zero read as one
      logic [7:0]           epoch_count;
      logic [15:0]          motor_delay;
      logic [16:0]          motor_end;     // delay + duration
      logic                 motor_enable;
      logic                 armed;
      logic [TotalBits-1:0] total;
   } cfg_type;

   // Up to two event words raised by one input word
   typedef struct packed {
      logic [1:0] num;
      rsp_type    word1;
      rsp_type    word0;
   } push_type;

   function automatic rsp_type make_event(logic [2:0] kind, logic [31:0] stamp,
                                          logic [31:0] value);
      rsp_type r;
      r               = '0;
      r.event_kind    = kind;
      r.event_time    = stamp;
      r.event_value   = value;
      return r;
   endfunction

endpackage

`default_nettype wire

### src/tesq_csr.sv
// Settings registers and the precomputed trial length.
`timescale 1ns / 1ps
`default_nettype none

module tesq_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [tesq_pkg::CsrIndexBits-1:0]     csr_index,
   input  wire logic [tesq_pkg::CsrDataBits-1:0]      csr_wr_data,
   output tesq_pkg::cfg_type                          cfg
);
   import tesq_pkg::*;

   logic [15:0]          pre_ff, post_ff, epoch_ff, delay_ff, motor_dur_ff;
   logic [7:0]           count_ff;
   logic                 enable_ff, armed_ff;
   logic [TotalBits-1:0] total_ff, total_in;
   logic [15:0]          epoch_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff       <= PreReset;
         post_ff      <= PostReset;
         epoch_ff     <= EpochDurReset;
         count_ff     <= EpochCntReset;
         delay_ff     <= DelayReset;
         motor_dur_ff <= MotorDurReset;
         enable_ff    <= 1'b0;
         armed_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_PRE_DURATION:   pre_ff       <= csr_wr_data;
            REG_POST_DURATION:  post_ff      <= csr_wr_data;
            REG_EPOCH_DURATION: epoch_ff     <= csr_wr_data;
            REG_EPOCH_COUNT:    count_ff     <= csr_wr_data[7:0];
            REG_MOTOR_DELAY:    delay_ff     <= csr_wr_data;
            REG_MOTOR_DURATION: motor_dur_ff <= csr_wr_data;
            REG_MOTOR_ENABLE:   enable_ff    <= csr_wr_data[0];
            REG_ARMED:          armed_ff     <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   assign epoch_len = (epoch_ff == 16'd0) ? 16'd1 : epoch_ff;

   // Trial length is registered and follows the settings in the next cycle
   assign total_in = TotalBits'(pre_ff) + TotalBits'(post_ff)
                   + TotalBits'(24'(epoch_len) * 24'(count_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TotalReset;
      end else begin
         total_ff <= total_in;
      end
   end

   always_comb begin
      cfg.pre_duration = pre_ff;
      cfg.epoch_len    = epoch_len;
      cfg.epoch_count  = count_ff;
      cfg.motor_delay  = delay_ff;
      cfg.motor_end    = 17'(delay_ff) + 17'(motor_dur_ff);
      cfg.motor_enable = enable_ff;
      cfg.armed        = armed_ff;
      cfg.total        = total_ff;
   end

endmodule

`default_nettype wire

### src/tesq_core.sv
// Input register, trial state and event generation.
`timescale 1ns / 1ps
`default_nettype none

module tesq_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  tesq_pkg::req_type       req_data,
   input  tesq_pkg::cfg_type       cfg,
   input  wire logic               room,
   output tesq_pkg::push_type      push
);
   import tesq_pkg::*;

   req_type               in_ff;
   logic                  in_valid_ff, in_valid_in;
   logic                  go;

   logic                  running_ff, running_in;
   logic                  motor_ff, motor_in;
   logic                  active_ff, active_in;
   logic [15:0]           number_ff, number_in;
   logic [TimeBits-1:0]   time_ff, time_in;
   logic [7:0]            epoch_ff, epoch_in;
   logic [15:0]           phase_ff, phase_in;
   logic [15:0]           frame_ff, frame_in;
   logic [31:0]           wheel_ff, wheel_in;
   logic [31:0]           report_ff, report_in;

   logic [TimeBits-1:0]   time_inc;
   logic [15:0]           phase_inc;
   logic                  window;
   logic [1:0]            num;
   rsp_type               res [2];

   assign go          = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   always_comb begin
      running_in = running_ff;
      motor_in   = motor_ff;
      active_in  = active_ff;
      number_in  = number_ff;
      time_in    = time_ff;
      epoch_in   = epoch_ff;
      phase_in   = phase_ff;
      frame_in   = frame_ff;
      wheel_in   = wheel_ff;
      report_in  = report_ff;
      time_inc   = time_ff + 1'b1;
      phase_inc  = phase_ff + 1'b1;
      window     = 1'b0;
      num        = 2'd0;
      res[0]     = '0;
      res[1]     = '0;

      if (go) begin
         unique case (in_ff.action)
            ACT_TICK: begin
               if (running_ff) begin
                  time_in = time_inc;
                  if (CmpBits'(time_inc) > CmpBits'(cfg.total)) begin
                     running_in = 1'b0;
                     motor_in   = 1'b0;
                     active_in  = 1'b0;
                     res[0]     = make_event(EV_TRIAL_STOP, 32'(time_inc), 32'(number_ff));
                     num        = 2'd1;
                  end else begin
                     if (!active_ff) begin
                        if (epoch_ff == 8'd0 && time_inc == TimeBits'(cfg.pre_duration)
                            && cfg.epoch_count != 8'd0) begin
                           active_in = 1'b1;
                           epoch_in  = 8'd1;
                           phase_in  = 16'd0;
                           res[0]    = make_event(EV_EPOCH_START, 32'(time_inc), 32'd1);
                           num       = 2'd1;
                        end
                     end else if (phase_inc >= cfg.epoch_len) begin
                        phase_in = 16'd0;
                        if (epoch_ff < cfg.epoch_count) begin
                           epoch_in = epoch_ff + 1'b1;
                           res[0]   = make_event(EV_EPOCH_START, 32'(time_inc),
                                                 32'(epoch_ff + 1'b1));
                           num      = 2'd1;
                        end else begin
                           active_in = 1'b0;
                        end
                     end else begin
                        phase_in = phase_inc;
                     end

                     window = cfg.motor_enable && active_in && phase_in > cfg.motor_delay
                           && 17'(phase_in) <= cfg.motor_end;
                     if (!motor_ff && window) begin
                        motor_in    = 1'b1;
                        res[num[0]] = make_event(EV_MOTOR_ON, 32'(time_inc), 32'(epoch_in));
                        num         = num + 1'b1;
                     end else if (motor_ff && !window) begin
                        motor_in    = 1'b0;
                        res[num[0]] = make_event(EV_MOTOR_OFF, 32'(time_inc), 32'(epoch_in));
                        num         = num + 1'b1;
                     end
                  end
               end
            end
            ACT_START: begin
               if (!running_ff && (in_ff.from_host || cfg.armed)) begin
                  number_in  = number_ff + 1'b1;
                  time_in    = '0;
                  epoch_in   = 8'd0;
                  phase_in   = 16'd0;
                  frame_in   = 16'd0;
                  motor_in   = 1'b0;
                  active_in  = 1'b0;
                  running_in = 1'b1;
                  res[0]     = make_event(EV_TRIAL_START, 32'd0, 32'(number_in));
                  num        = 2'd1;
                  // Zero pre period: epoch one opens with the trial
                  if (cfg.pre_duration == 16'd0 && cfg.epoch_count != 8'd0) begin
                     active_in = 1'b1;
                     epoch_in  = 8'd1;
                     res[1]    = make_event(EV_EPOCH_START, 32'd0, 32'd1);
                     num       = 2'd2;
                  end
               end
            end
            ACT_STOP: begin
               if (running_ff) begin
                  running_in = 1'b0;
                  motor_in   = 1'b0;
                  active_in  = 1'b0;
                  res[0]     = make_event(EV_TRIAL_STOP, 32'(time_ff), 32'(number_ff));
                  num        = 2'd1;
               end
            end
            ACT_FRAME: begin
               if (running_ff) begin
                  frame_in = frame_ff + 1'b1;
                  res[0]   = make_event(EV_FRAME, 32'(time_ff), 32'(frame_in));
                  num      = 2'd1;
               end
            end
            ACT_ENCODER: begin
               if (in_ff.encoder_position != wheel_ff) begin
                  wheel_in = in_ff.encoder_position;
                  if (!cfg.motor_enable
                      && (32'(time_ff) - report_ff) > 32'(ReportInterval)) begin
                     report_in = 32'(time_ff);
                     res[0]    = make_event(EV_ENCODER, 32'(time_ff), in_ff.encoder_position);
                     num       = 2'd1;
                  end
               end
            end
            default: ;
         endcase
      end

      res[0].trial_running = running_in;
      res[0].motor_on      = motor_in;
      res[0].last          = (num == 2'd1);
      res[1].trial_running = running_in;
      res[1].motor_on      = motor_in;
      res[1].last          = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         motor_ff   <= 1'b0;
         active_ff  <= 1'b0;
         number_ff  <= 16'd0;
         time_ff    <= '0;
         epoch_ff   <= 8'd0;
         phase_ff   <= 16'd0;
         frame_ff   <= 16'd0;
         wheel_ff   <= WheelReset;
         report_ff  <= WheelReset;
      end else begin
         running_ff <= running_in;
         motor_ff   <= motor_in;
         active_ff  <= active_in;
         number_ff  <= number_in;
         time_ff    <= time_in;
         epoch_ff   <= epoch_in;
         phase_ff   <= phase_in;
         frame_ff   <= frame_in;
         wheel_ff   <= wheel_in;
         report_ff  <= report_in;
      end
   end

   always_comb begin
      push.num   = num;
      push.word0 = res[0];
      push.word1 = res[1];
   end

endmodule

`default_nettype wire

### src/tesq_rsp_fifo.sv
// Result queue: takes up to two words a cycle, hands out one unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module tesq_rsp_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  tesq_pkg::push_type      push,
   output logic                    room,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output tesq_pkg::rsp_type       rsp_data
);
   import tesq_pkg::*;

   rsp_type                mem [FifoDepth];
   logic [PtrBits-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]   count_ff, count_in;
   logic                   pop;
   logic [PtrBits-1:0]     wr_next;

   assign pop       = (count_ff != '0) && !rsp_stall;
   assign wr_next   = wr_ptr_ff + 1'b1;
   assign room      = count_ff <= CountBits'(FifoDepth - 2);
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + PtrBits'(push.num);
   assign rd_ptr_in = rd_ptr_ff + PtrBits'(pop);
   assign count_in  = count_ff + CountBits'(push.num) - CountBits'(pop);

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem[wr_ptr_ff] <= push.word0;
      end
      if (push.num == 2'd2) begin
         mem[wr_next] <= push.word1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### src/trial_epoch_motor_sequencer_unit.sv
// Top level of the trial epoch motor sequencer.
//
//   channel   ports          direction   word
//   -------   ------------   ---------   -----------------------------------------
//   request   req_*          in          action, from_host, encoder_position
//   response  rsp_*          out         event_kind/time/value, running, motor, last
//   settings  csr_*          in          write enable, register index, 16-bit data
//
// A request word is taken into an input register and worked through once the
// queue has room, so one word a cycle is accepted while not stalled. A word raises
// zero, one or two events; they go into a four-word result queue, and the request
// side stalls while the queue has fewer than two free places. Words raising two
// events are thus handed out one word at a time. Reset is synchronous and active
// high; it restores the default settings, clears the trial state and empties the
// queue. A written setting is registered, then the trial length register follows.
`timescale 1ns / 1ps
`default_nettype none

module trial_epoch_motor_sequencer_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  tesq_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output tesq_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_wr_en,
   input  wire logic [tesq_pkg::CsrIndexBits-1:0]  csr_index,
   input  wire logic [tesq_pkg::CsrDataBits-1:0]   csr_wr_data
);
   import tesq_pkg::*;

   cfg_type  cfg;
   push_type push;
   logic     room;

   // Settings and precomputed trial length
   tesq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // Trial timing: tick, start, stop, frame and encoder handling
   tesq_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg),
      .room      (room),
      .push      (push)
   );

   // Hold events until the consumer takes them
   tesq_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### src/tesq_checker.sv
// Port-level checks for the sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tesq_checker (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rsp_valid,
   input  wire logic          rsp_stall,
   input  tesq_pkg::rsp_type  rsp_data
);
   import tesq_pkg::*;

   // A stalled event word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("event word changed while stalled");

   // Never report an empty event
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.event_kind != 3'd0)
      else $error("event word with no kind");

   // Motor can only run inside a trial
   a_motor_trial: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.motor_on |-> rsp_data.trial_running)
      else $error("motor on outside a trial");

   // Trial start is stamped zero and leaves the trial running
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == EV_TRIAL_START
      |-> rsp_data.trial_running && rsp_data.event_time == 32'd0)
      else $error("bad trial start word");

   // Trial stop leaves both trial and motor idle and is the last word
   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == EV_TRIAL_STOP
      |-> !rsp_data.trial_running && !rsp_data.motor_on && rsp_data.last)
      else $error("bad trial stop word");

endmodule

bind trial_epoch_motor_sequencer_unit tesq_checker u_tesq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### sim/tesq_event_checker.sv
// Event checker for the trial epoch motor sequencer: predicts and compares every event word.
`timescale 1ns / 1ps

module tesq_event_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  tesq_pkg::req_type                        req_data,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  tesq_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [tesq_pkg::CsrIndexBits-1:0]   csr_index,
   input  wire logic [tesq_pkg::CsrDataBits-1:0]    csr_wr_data,
   output int                                       mismatches,
   output int                                       awaited,
   output int                                       events_checked
);
   import tesq_pkg::*;

   localparam int PrintLimit = 40;

   // settings
   logic [15:0] pre_ms, post_ms, epoch_ms, delay_ms, window_ms;
   logic [7:0]  epochs_per_trial;
   logic        motor_used, trigger_armed;

   // trial state
   logic        in_trial, motor_live, in_epoch;
   logic [15:0] trial_id, phase_ms, frames;
   logic [7:0]  epoch_no;
   logic [31:0] clock_ms, wheel_pos, wheel_stamp;

   rsp_type     awaited_events[$];
   rsp_type     staged[2];
   int          staged_n;

   initial begin
      mismatches     = 0;
      events_checked = 0;
      awaited        = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatches < PrintLimit)
         $display("%0t ns: event %0d %s: expected %h, got %h",
                  $time, events_checked, what, want, got);
      mismatches++;
   endtask

   function automatic logic [15:0] epoch_len();
      return (epoch_ms == 16'd0) ? 16'd1 : epoch_ms;
   endfunction

   task automatic stage(input logic [2:0] kind, input logic [31:0] stamp,
                        input logic [31:0] value);
      rsp_type r;
      r             = '0;
      r.event_kind  = kind;
      r.event_time  = stamp;
      r.event_value = value;
      staged[staged_n] = r;
      staged_n++;
   endtask

   task automatic end_trial();
      in_trial   = 1'b0;
      motor_live = 1'b0;
      in_epoch   = 1'b0;
      stage(EV_TRIAL_STOP, clock_ms, {16'd0, trial_id});
   endtask

   task automatic open_first_epoch();
      if (!in_epoch && epoch_no == 8'd0 && clock_ms == {16'd0, pre_ms}
          && epochs_per_trial != 8'd0) begin
         in_epoch = 1'b1;
         epoch_no = 8'd1;
         phase_ms = 16'd0;
         stage(EV_EPOCH_START, clock_ms, {24'd0, epoch_no});
      end
   endtask

   task automatic advance_clock();
      logic [63:0] limit_ms;
      logic        window;
      if (in_trial) begin
         clock_ms = clock_ms + 32'd1;
         limit_ms = {48'd0, pre_ms} + {48'd0, epoch_len()} * {56'd0, epochs_per_trial}
                  + {48'd0, post_ms};
         if ({32'd0, clock_ms} > limit_ms) begin
            end_trial();
         end else begin
            if (!in_epoch) begin
               open_first_epoch();
            end else begin
               phase_ms = phase_ms + 16'd1;
               if (phase_ms >= epoch_len()) begin
                  phase_ms = 16'd0;
                  if (epoch_no < epochs_per_trial) begin
                     epoch_no = epoch_no + 8'd1;
                     stage(EV_EPOCH_START, clock_ms, {24'd0, epoch_no});
                  end else begin
                     in_epoch = 1'b0;
                  end
               end
            end
            // epoch start is staged before any motor edge
            window = motor_used && in_epoch && phase_ms > delay_ms
                  && {1'b0, phase_ms} <= {1'b0, delay_ms} + {1'b0, window_ms};
            if (!motor_live && window) begin
               motor_live = 1'b1;
               stage(EV_MOTOR_ON, clock_ms, {24'd0, epoch_no});
            end else if (motor_live && !window) begin
               motor_live = 1'b0;
               stage(EV_MOTOR_OFF, clock_ms, {24'd0, epoch_no});
            end
         end
      end
   endtask

   task automatic predict_events(input req_type w);
      staged_n = 0;
      case (w.action)
         ACT_TICK: advance_clock();
         ACT_START: begin
            if (!in_trial && (w.from_host || trigger_armed)) begin
               trial_id   = trial_id + 16'd1;
               clock_ms   = 32'd0;
               epoch_no   = 8'd0;
               phase_ms   = 16'd0;
               frames     = 16'd0;
               motor_live = 1'b0;
               in_epoch   = 1'b0;
               in_trial   = 1'b1;
               stage(EV_TRIAL_START, 32'd0, {16'd0, trial_id});
               open_first_epoch();
            end
         end
         ACT_STOP: begin
            if (in_trial) end_trial();
         end
         ACT_FRAME: begin
            if (in_trial) begin
               frames = frames + 16'd1;
               stage(EV_FRAME, clock_ms, {16'd0, frames});
            end
         end
         ACT_ENCODER: begin
            // an idle block still tracks the wheel, stamped with the frozen clock
            if (w.encoder_position != wheel_pos) begin
               wheel_pos = w.encoder_position;
               if (!motor_used && (clock_ms - wheel_stamp) > ReportInterval) begin
                  wheel_stamp = clock_ms;
                  stage(EV_ENCODER, clock_ms, wheel_pos);
               end
            end
         end
         default: ;
      endcase
      for (int k = 0; k < staged_n; k++) begin
         staged[k].trial_running = in_trial;
         staged[k].motor_on      = motor_live;
         staged[k].last          = (k == staged_n - 1);
         awaited_events.push_back(staged[k]);
      end
   endtask

   task automatic write_setting(input logic [CsrIndexBits-1:0] idx,
                                input logic [CsrDataBits-1:0] value);
      case (idx)
         REG_PRE_DURATION:   pre_ms           = value;
         REG_POST_DURATION:  post_ms          = value;
         REG_EPOCH_DURATION: epoch_ms         = value;
         REG_EPOCH_COUNT:    epochs_per_trial = value[7:0];
         REG_MOTOR_DELAY:    delay_ms         = value;
         REG_MOTOR_DURATION: window_ms        = value;
         REG_MOTOR_ENABLE:   motor_used       = value[0];
         REG_ARMED:          trigger_armed    = value[0];
         default: ;
      endcase
   endtask

   task automatic check_event(input rsp_type got);
      rsp_type want;
      if (awaited_events.size() == 0) begin
         report_mismatch("arrived with nothing awaited, kind", 32'd0, {29'd0, got.event_kind});
      end else begin
         want = awaited_events.pop_front();
         if (got.event_kind !== want.event_kind)
            report_mismatch("kind", {29'd0, want.event_kind}, {29'd0, got.event_kind});
         if (got.event_time !== want.event_time)
            report_mismatch("time", want.event_time, got.event_time);
         if (got.event_value !== want.event_value)
            report_mismatch("value", want.event_value, got.event_value);
         if (got.trial_running !== want.trial_running)
            report_mismatch("trial_running", {31'd0, want.trial_running},
                            {31'd0, got.trial_running});
         if (got.motor_on !== want.motor_on)
            report_mismatch("motor_on", {31'd0, want.motor_on}, {31'd0, got.motor_on});
         if (got.last !== want.last)
            report_mismatch("last", {31'd0, want.last}, {31'd0, got.last});
      end
      events_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pre_ms           = PreReset;
         post_ms          = PostReset;
         epoch_ms         = EpochDurReset;
         epochs_per_trial = EpochCntReset;
         delay_ms         = DelayReset;
         window_ms        = MotorDurReset;
         motor_used       = 1'b0;
         trigger_armed    = 1'b0;
         in_trial         = 1'b0;
         motor_live       = 1'b0;
         in_epoch         = 1'b0;
         trial_id         = 16'd0;
         phase_ms         = 16'd0;
         frames           = 16'd0;
         epoch_no         = 8'd0;
         clock_ms         = 32'd0;
         wheel_pos        = WheelReset;
         wheel_stamp      = WheelReset;
         awaited_events.delete();
      end else begin
         if (csr_wr_en) write_setting(csr_index, csr_wr_data);
         if (rsp_valid && !rsp_stall) check_event(rsp_data);
         if (req_valid && !req_stall) predict_events(req_data);
      end
      awaited <= awaited_events.size();
   end

endmodule

### sim/trial_epoch_motor_sequencer_unit_test.sv
// Stimulus and verdict for the trial epoch motor sequencer, checked by tesq_event_checker.
`timescale 1ns / 1ps

module trial_epoch_motor_sequencer_unit_test;
   import tesq_pkg::*;

   // Cycles to let the block finish a word that raised no event: input
   // register plus working stage plus a little slack.
   localparam int SettleCycles = 8;
   localparam int RandomWords  = 550;
   localparam int IdlePercent  = 37;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   req_type                 req_data    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_wr_en   = 1'b0;
   logic [CsrIndexBits-1:0] csr_index   = '0;
   logic [CsrDataBits-1:0]  csr_wr_data = '0;

   int                      mismatches;
   int                      awaited;
   int                      events_checked;

   // Stimulus bookkeeping
   logic                    calm = 1'b0;      // high: neither side idles
   logic [31:0]             last_pos = WheelReset;
   int                      words_sent = 0;
   int                      setting_rounds = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   trial_epoch_motor_sequencer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   tesq_event_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatches     (mismatches),
      .awaited        (awaited),
      .events_checked (events_checked)
   );

   // Event sink: stall at random unless a calm stretch is running. The stall
   // is drawn afresh every cycle, so it lands on every phase of the queue.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IdlePercent);
   end

   function automatic req_type make_word(input logic [2:0] act, input logic host,
                                         input logic [31:0] pos);
      req_type w;
      w.action           = act;
      w.from_host        = host;
      w.encoder_position = pos;
      return w;
   endfunction

   // Offer one word and hold it until the block takes it. Idle gaps go in
   // front of the word, never while a word is waiting, so valid is never
   // dropped under a stall and the payload stays put.
   task automatic send_word(input req_type w);
      while (!calm && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (w.action == ACT_ENCODER) last_pos = w.encoder_position;
      words_sent++;
   endtask

   // Drop valid, wait for every awaited event, then give the block time to
   // finish any word that raised nothing.
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_setting(input logic [CsrIndexBits-1:0] idx,
                                input logic [CsrDataBits-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
   endtask

   // Write all eight registers back to back while the block is quiet, then
   // hold off so the trial length register catches up.
   task automatic apply_settings(input int unsigned pre, input int unsigned post,
                                 input int unsigned epoch, input int unsigned count,
                                 input int unsigned delay, input int unsigned dur,
                                 input int unsigned motor, input int unsigned arm);
      quiesce();
      write_setting(REG_PRE_DURATION,   pre[15:0]);
      write_setting(REG_POST_DURATION,  post[15:0]);
      write_setting(REG_EPOCH_DURATION, epoch[15:0]);
      write_setting(REG_EPOCH_COUNT,    count[15:0]);
      write_setting(REG_MOTOR_DELAY,    delay[15:0]);
      write_setting(REG_MOTOR_DURATION, dur[15:0]);
      write_setting(REG_MOTOR_ENABLE,   motor[15:0]);
      write_setting(REG_ARMED,          arm[15:0]);
      csr_wr_en <= 1'b0;
      repeat (2) @(posedge clock);
      setting_rounds++;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_word(make_word(ACT_TICK, 1'b0, 32'd0));
   endtask

   // Mostly ticks, with frames and wheel samples scattered through the trial,
   // and a little noise: stray stops and starts and unknown actions. Every
   // field carries random bits even where the action ignores them.
   task automatic send_random_word();
      int unsigned pick;
      int unsigned spare;
      logic [2:0]  act;
      logic [31:0] pos;
      pick = $urandom_range(99);
      pos  = $urandom;
      if (pick < 62) begin
         act = ACT_TICK;
      end else if (pick < 74) begin
         act = ACT_FRAME;
      end else if (pick < 86) begin
         act = ACT_ENCODER;
         // repeat the wheel position now and then: no report is due
         if ($urandom_range(3) == 0) pos = last_pos;
      end else if (pick < 90) begin
         act = ACT_STOP;
      end else if (pick < 95) begin
         act = ACT_START;
      end else begin
         spare = $urandom_range(2);
         act   = ACT_ENCODER + 3'd1 + spare[2:0];
      end
      send_word(make_word(act, ($urandom_range(1) != 0), pos));
   endtask

   // One well-formed trial: optionally close any trial left over, start a new
   // one (by host mostly, by trigger otherwise) and run it on random words.
   task automatic run_trial(input int length);
      if ($urandom_range(1) != 0) send_word(make_word(ACT_STOP, 1'b0, $urandom));
      send_word(make_word(ACT_START, ($urandom_range(3) != 0), $urandom));
      repeat (length) send_random_word();
   endtask

   initial begin
      int phase_no;
      int spread_start;
      int length;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words on the reset settings: idle block first.
      send_word(make_word(ACT_TICK,    1'b0, 32'd0));          // no trial: nothing
      send_word(make_word(ACT_STOP,    1'b0, 32'd0));          // no trial: nothing
      send_word(make_word(ACT_FRAME,   1'b0, 32'd0));          // no trial: nothing
      send_word(make_word(ACT_ENCODER, 1'b0, WheelReset));     // unchanged wheel
      send_word(make_word(ACT_ENCODER, 1'b0, 32'h7FFF_FFFF));  // reported at frozen time
      send_word(make_word(ACT_ENCODER, 1'b0, 32'h8000_0000));  // too soon to report
      send_word(make_word(ACT_ENCODER + 3'd1, 1'b1, 32'hFFFF_FFFF));
      send_word(make_word(ACT_ENCODER + 3'd2, 1'b1, 32'hFFFF_FFFF));
      send_word(make_word(ACT_ENCODER + 3'd3, 1'b1, 32'hFFFF_FFFF));
      send_word(make_word(ACT_START,   1'b0, 32'd0));          // trigger, not armed
      send_word(make_word(ACT_START,   1'b1, 32'd0));          // host start
      send_word(make_word(ACT_START,   1'b1, 32'd0));          // already running
      send_word(make_word(ACT_FRAME,   1'b0, 32'd0));
      send_ticks(1);
      send_word(make_word(ACT_STOP,    1'b0, 32'd0));

      // No pre period and zero epoch length: trial and epoch start together,
      // each epoch lasts one tick; armed trigger starts the trial.
      apply_settings(0, 1, 0, 2, 0, 1, 1, 1);
      send_word(make_word(ACT_START, 1'b0, 32'd0));
      send_ticks(4);

      // No epochs at all: the trial runs pre plus post and stops by itself.
      apply_settings(2, 1, 4, 0, 0, 2, 1, 0);
      send_word(make_word(ACT_START, 1'b1, 32'd0));
      send_ticks(4);

      // Random trials. Most settings are small so trials end and windows
      // open often; a few phases take the minimum and maximum settings and a
      // longer trial lets wheel reports fall due inside a running trial.
      spread_start = words_sent;
      phase_no     = 0;
      while (words_sent - spread_start < RandomWords) begin
         length = $urandom_range(50, 30);
         if (phase_no == 1) begin
            apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
         end else if (phase_no == 3) begin
            apply_settings(65535, 65535, 65535, 255, 65535, 65535, 1, 1);
         end else if (phase_no % 4 == 2) begin
            apply_settings($urandom_range(60, 20), $urandom_range(40, 10),
                           $urandom_range(20, 5), $urandom_range(4, 1),
                           $urandom_range(10), $urandom_range(10),
                           $urandom_range(1), $urandom_range(1));
            length = 120;
         end else begin
            apply_settings($urandom_range(6), $urandom_range(6), $urandom_range(8),
                           $urandom_range(4), $urandom_range(5), $urandom_range(5),
                           $urandom_range(1), $urandom_range(1));
         end
         // Hold both sides busy for one whole, longer phase.
         if (phase_no == 5) begin
            calm <= 1'b1;
            apply_settings($urandom_range(6), $urandom_range(6), $urandom_range(8),
                           $urandom_range(4), $urandom_range(5), $urandom_range(5),
                           1, 0);
            length = 120;
         end else if (phase_no == 6) begin
            calm <= 1'b0;
         end
         run_trial(length);
         phase_no++;
      end

      quiesce();
      $display("Covered %0d request words over %0d setting rounds.",
               words_sent, setting_rounds);
      $display("Compared %0d events word by word, %0d mismatches.", events_checked,
               mismatches);
      if (mismatches == 0)
         $display("trial_epoch_motor_sequencer_unit test passed");
      else
         $display("trial_epoch_motor_sequencer_unit test failed");
      $finish;
   end

   // Guard against a hung handshake: well past the slowest correct run.
   initial begin
      #40_000_000;
      $display("Timed out waiting on the block.");
      $display("trial_epoch_motor_sequencer_unit test failed");
      $finish;
   end

endmodule
